[design/dfs_adjacency_matrix_order_unit_defines.svh]
// Assertion macros used by dfsam_walk.
`ifndef DFS_ADJACENCY_MATRIX_ORDER_UNIT_DEFINES_SVH
`define DFS_ADJACENCY_MATRIX_ORDER_UNIT_DEFINES_SVH

// A condition that holds at every clock edge outside reset.
`define DFSAM_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// A condition that implies another one in the next cycle.
`define DFSAM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// A condition that implies another one in the same cycle.
`define DFSAM_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

[design/dfsam_pkg.sv]
package dfsam_pkg;

	localparam int MAX_NODES = 16;
	localparam int NODE_W = $clog2(MAX_NODES);
	localparam int CNT_W = $clog2(MAX_NODES + 1);
	localparam logic [CNT_W-1:0] NODE_COUNT_RESET = CNT_W'(MAX_NODES);

	typedef struct packed {
		logic [NODE_W-1:0]    row_index;
		logic [MAX_NODES-1:0] row_bits;
		logic                 run_now;
	} row_word_t;

	typedef struct packed {
		logic [CNT_W-1:0] visited_node;
		logic             last_in_run;
	} order_word_t;

	typedef struct packed {
		logic              valid;
		order_word_t       word;
	} emit_t;

	typedef struct packed {
		logic              we;
		logic [NODE_W-1:0] addr;
		logic [NODE_W-1:0] data;
	} stk_wr_t;

	function automatic logic [CNT_W-1:0] nodes_in_use(input logic [CNT_W-1:0] cfg);
		logic [CNT_W-1:0] n;
		n = cfg;
		if (n == '0) begin
			n = CNT_W'(1);
		end
		if (n > CNT_W'(MAX_NODES)) begin
			n = CNT_W'(MAX_NODES);
		end
		return n;
	endfunction

	function automatic logic [MAX_NODES-1:0] use_mask(input logic [CNT_W-1:0] n);
		logic [MAX_NODES-1:0] m;
		m = '0;
		for (int i = 0; i < MAX_NODES; i++) begin
			m[i] = (CNT_W'(i) < n);
		end
		return m;
	endfunction

	function automatic logic [NODE_W-1:0] lowest_set(input logic [MAX_NODES-1:0] v);
		logic [NODE_W-1:0] r;
		r = '0;
		for (int i = MAX_NODES - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = NODE_W'(i);
			end
		end
		return r;
	endfunction

	function automatic logic [NODE_W-1:0] highest_set(input logic [MAX_NODES-1:0] v);
		logic [NODE_W-1:0] r;
		r = '0;
		for (int i = 0; i < MAX_NODES; i++) begin
			if (v[i]) begin
				r = NODE_W'(i);
			end
		end
		return r;
	endfunction

endpackage

[design/dfsam_ram.sv]
module dfsam_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[design/dfsam_walk.sv]
`include "dfs_adjacency_matrix_order_unit_defines.svh"

module dfsam_walk import dfsam_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [CNT_W-1:0]     n_use,
	output logic                 busy,
	output logic [NODE_W-1:0]    adj_raddr,
	input  logic [MAX_NODES-1:0] adj_rdata,
	output stk_wr_t              stk_wr,
	output logic [NODE_W-1:0]    stk_raddr,
	input  logic [NODE_W-1:0]    stk_rdata,
	output emit_t                emit,
	input  logic                 emit_ready
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_VISIT = 4'b0010,
		S_EVAL  = 4'b0100,
		S_POP   = 4'b1000
	} walk_state_t;

	walk_state_t          st_q;
	logic [NODE_W-1:0]    pick_q;
	logic [MAX_NODES-1:0] vis_q;
	logic [MAX_NODES-1:0] all_q;
	logic [CNT_W-1:0]     sp_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [CNT_W-1:0]     n_q;

	logic [MAX_NODES-1:0] cand;
	logic [MAX_NODES-1:0] left;
	logic [CNT_W-1:0]     sp_dec;
	logic [CNT_W-1:0]     cnt_inc;
	logic                 visit_go;
	logic                 last;

	assign cand = adj_rdata & all_q & ~vis_q;
	assign left = all_q & ~vis_q;
	assign sp_dec = sp_q - CNT_W'(1);
	assign cnt_inc = cnt_q + CNT_W'(1);
	assign visit_go = (st_q == S_VISIT) && emit_ready;
	assign last = (cnt_inc == n_q);
	assign busy = (st_q != S_IDLE);

	assign emit.valid = visit_go;
	assign emit.word.visited_node = CNT_W'(pick_q) + CNT_W'(1);
	assign emit.word.last_in_run = last;

	assign stk_wr.we = visit_go;
	assign stk_wr.addr = sp_q[NODE_W-1:0];
	assign stk_wr.data = pick_q;

	// After a pop the new top sits two below the current depth.
	assign stk_raddr = NODE_W'(sp_q - CNT_W'(2));
	assign adj_raddr = (st_q == S_POP) ? stk_rdata : pick_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			pick_q <= '0;
			vis_q <= '0;
			all_q <= '0;
			sp_q <= '0;
			cnt_q <= '0;
			n_q <= '0;
		end else begin
			unique case (st_q)
				S_IDLE: begin
					if (start) begin
						n_q <= n_use;
						all_q <= use_mask(n_use);
						vis_q <= '0;
						sp_q <= '0;
						cnt_q <= '0;
						pick_q <= '0;
						st_q <= S_VISIT;
					end
				end
				S_VISIT: begin
					if (emit_ready) begin
						vis_q <= vis_q | (MAX_NODES'(1) << pick_q);
						sp_q <= sp_q + CNT_W'(1);
						cnt_q <= cnt_inc;
						st_q <= last ? S_IDLE : S_EVAL;
					end
				end
				S_EVAL: begin
					if (cand != '0) begin
						pick_q <= lowest_set(cand);
						st_q <= S_VISIT;
					end else begin
						sp_q <= sp_dec;
						if (sp_dec == '0) begin
							pick_q <= highest_set(left);
							st_q <= S_VISIT;
						end else begin
							st_q <= S_POP;
						end
					end
				end
				S_POP: begin
					st_q <= S_EVAL;
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	`DFSAM_ASSERT_ALWAYS(a_vis_matches_cnt, $countones(vis_q) == cnt_q, "visited set and count differ")
	`DFSAM_ASSERT_ALWAYS(a_sp_le_cnt, sp_q <= cnt_q, "path stack deeper than visit count")
	`DFSAM_ASSERT_SAME(a_start_idle, start, st_q == S_IDLE, "run started while busy")
	`DFSAM_ASSERT_SAME(a_eval_open, st_q == S_EVAL, cnt_q < n_q, "search step after all nodes seen")
	`DFSAM_ASSERT_NEXT(a_last_ends, emit.valid && emit.word.last_in_run, st_q == S_IDLE,
		"walk continues after its last word")

endmodule

[design/dfs_adjacency_matrix_order_unit.sv]
// Channel   Handshake              Word
// row       row_valid/row_ready    row_word_t: row_index, row_bits, run_now
// order     order_valid/order_ready order_word_t: visited_node, last_in_run
// config    cfg_wr_en              cfg_wr_data: node_count
//
// Rows are accepted back to back while no run is active.
// A run visits each node once, pops the path stack on each backtrack that leaves it
// nonempty, and waits on the registered reads of the adjacency and path stack memories;
// row_ready is low until it ends.
// A stalled order channel holds the walk at its next visit; one finished word waits
// in the output register. Reset clears the control state and sets node_count to 16.
module dfs_adjacency_matrix_order_unit import dfsam_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             row_valid,
	output logic             row_ready,
	input  row_word_t        row,
	output logic             order_valid,
	input  logic             order_ready,
	output order_word_t      order,
	input  logic             cfg_wr_en,
	input  logic [CNT_W-1:0] cfg_wr_data
);

	logic [CNT_W-1:0]     ncfg_q;
	logic                 out_valid_q;
	order_word_t          out_q;

	logic                 busy;
	logic                 row_acc;
	logic                 emit_ready;
	emit_t                emit;
	stk_wr_t              stk_wr;
	logic [NODE_W-1:0]    adj_raddr;
	logic [MAX_NODES-1:0] adj_rdata;
	logic [NODE_W-1:0]    stk_raddr;
	logic [NODE_W-1:0]    stk_rdata;

	assign row_ready = !busy;
	assign row_acc = row_valid && row_ready;
	assign emit_ready = !out_valid_q || order_ready;
	assign order_valid = out_valid_q;
	assign order = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ncfg_q <= NODE_COUNT_RESET;
		end else if (cfg_wr_en) begin
			ncfg_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit.valid) begin
			out_valid_q <= 1'b1;
		end else if (order_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.valid) begin
			out_q <= emit.word;
		end
	end

	dfsam_ram #(
		.WIDTH(MAX_NODES),
		.DEPTH(MAX_NODES)
	) u_adj_ram (
		.clk  (clk),
		.we   (row_acc),
		.waddr(row.row_index),
		.wdata(row.row_bits),
		.raddr(adj_raddr),
		.rdata(adj_rdata)
	);

	dfsam_ram #(
		.WIDTH(NODE_W),
		.DEPTH(MAX_NODES)
	) u_stk_ram (
		.clk  (clk),
		.we   (stk_wr.we),
		.waddr(stk_wr.addr),
		.wdata(stk_wr.data),
		.raddr(stk_raddr),
		.rdata(stk_rdata)
	);

	dfsam_walk u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (row_acc && row.run_now),
		.n_use     (nodes_in_use(ncfg_q)),
		.busy      (busy),
		.adj_raddr (adj_raddr),
		.adj_rdata (adj_rdata),
		.stk_wr    (stk_wr),
		.stk_raddr (stk_raddr),
		.stk_rdata (stk_rdata),
		.emit      (emit),
		.emit_ready(emit_ready)
	);

endmodule
